/* design/pfe_pkg.sv */
// Package for the Playfair encryptor: word types, sequencer/memory structs,
// letter codes, the letter mapping functions and the grid cell functions. No dependencies.
`default_nettype none

package pfe_pkg;

   localparam int CELLS = 25;
   localparam int SIDE  = 5;

   localparam logic [4:0] LAST_CELL     = 5'(CELLS - 1);
   localparam logic [4:0] FILLER_INDEX  = 5'd22;   // X
   localparam logic [2:0] LAST_ROW_COL  = 3'(SIDE - 1);

   localparam logic [7:0] ASCII_A       = 8'h41;
   localparam logic [7:0] ASCII_J       = 8'h4A;
   localparam logic [7:0] ASCII_Z       = 8'h5A;
   localparam logic [7:0] ASCII_LOWER_A = 8'h61;
   localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;
   localparam logic [7:0] CASE_OFFSET   = 8'h20;
   localparam logic [7:0] J_OFFSET      = ASCII_J - ASCII_A;

   localparam logic [1:0] MODE_KEY = 2'd0;
   localparam logic [1:0] MODE_MSG = 2'd1;
   localparam logic [1:0] MODE_END = 2'd2;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] in_byte;
   } req_word_type;

   typedef struct packed {
      logic [6:0] cipher_letter;
      logic       last;
   } rsp_word_type;

   typedef struct packed {
      logic         valid;
      rsp_word_type word;
   } emit_type;

   // grid RAM: write slot <- letter; position RAM: write letter <- slot
   typedef struct packed {
      logic       we;
      logic [4:0] slot;
      logic [4:0] letter;
      logic [4:0] grid_raddr;
      logic [4:0] pos_raddr;
   } mem_req_type;

   typedef struct packed {
      logic       ok;
      logic [4:0] idx;
   } letter_type;

   function automatic letter_type letter_index(input logic [7:0] b);
      logic [7:0] c;
      logic [7:0] t;
      letter_type r;
      c = b;
      if (c >= ASCII_LOWER_A && c <= ASCII_LOWER_Z) c = c - CASE_OFFSET;
      t = c - ASCII_A;
      if (t >= J_OFFSET) t = t - 8'd1;
      r.ok  = (c >= ASCII_A) && (c <= ASCII_Z);
      r.idx = t[4:0];
      return r;
   endfunction

   function automatic logic [6:0] letter_ascii(input logic [4:0] idx);
      logic [6:0] c;
      c = ASCII_A[6:0] + {2'b00, idx};
      if (idx >= J_OFFSET[4:0]) c = c + 7'd1;
      return c;
   endfunction

   function automatic logic [2:0] cell_row(input logic [4:0] pos);
      logic [2:0] r;
      if (pos >= 5'd20)      r = 3'd4;
      else if (pos >= 5'd15) r = 3'd3;
      else if (pos >= 5'd10) r = 3'd2;
      else if (pos >= 5'd5)  r = 3'd1;
      else                   r = 3'd0;
      return r;
   endfunction

   function automatic logic [4:0] cell_of(input logic [2:0] row, input logic [2:0] col);
      logic [4:0] r5;
      r5 = {2'b00, row};
      return (r5 << 2) + r5 + {2'b00, col};
   endfunction

   function automatic logic [2:0] cell_col(input logic [4:0] pos);
      logic [4:0] c;
      c = pos - cell_of(cell_row(pos), 3'd0);
      return c[2:0];
   endfunction

   function automatic logic [2:0] wrap_inc(input logic [2:0] v);
      return (v == LAST_ROW_COL) ? 3'd0 : v + 3'd1;
   endfunction

endpackage

`default_nettype wire

/* design/pfe_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module pfe_ram #(
   parameter int WIDTH = 5,
   parameter int DEPTH = 25
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* design/pfe_ctrl.sv */
// Playfair sequencer: key placement, grid completion sweep, pairing and
// pair encryption through the grid and position RAMs. Uses pfe_pkg.
`default_nettype none

module pfe_ctrl
   import pfe_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire req_word_type req_data,
   output logic              req_stall,
   input  wire logic [4:0]   pos_rdata,
   input  wire logic [4:0]   grid_rdata,
   input  wire logic         emit_ok,
   output mem_req_type       mem,
   output emit_type          emit
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_FILL, ST_PROC, ST_RDA, ST_RDB, ST_CELL, ST_GA, ST_GB, ST_EMIT0, ST_EMIT1
   } state_type;

   typedef enum logic [1:0] {PHASE_KEY, PHASE_MSG, PHASE_ENDED} phase_type;

   state_type  state_ff, state_in;
   phase_type  phase_ff, phase_in;
   logic [24:0] used_ff, used_in;
   logic [4:0] fill_ff, fill_in;
   logic [4:0] sweep_ff, sweep_in;
   logic [1:0] mode_ff, mode_in;
   letter_type lit_ff, lit_in;
   logic [4:0] pend_ff, pend_in;
   logic       pend_valid_ff, pend_valid_in;
   logic [4:0] a_ff, a_in, b_ff, b_in;
   logic [4:0] pa_ff, pa_in;
   logic [4:0] ob_ff, ob_in;
   logic [4:0] la_ff, la_in, lb_ff, lb_in;

   letter_type  lit;
   logic        place_en;
   logic [4:0]  place_idx;
   logic [24:0] used_base;
   logic [4:0]  fill_base;
   logic [2:0]  ra, ca, rb, cb;
   logic [4:0]  oa, ob;

   always_comb begin
      ra = cell_row(pa_ff);
      ca = cell_col(pa_ff);
      rb = cell_row(pos_rdata);
      cb = cell_col(pos_rdata);
      if (ra == rb) begin
         oa = cell_of(ra, wrap_inc(ca));
         ob = cell_of(rb, wrap_inc(cb));
      end else if (ca == cb) begin
         oa = cell_of(wrap_inc(ra), ca);
         ob = cell_of(wrap_inc(rb), cb);
      end else begin
         oa = cell_of(ra, cb);
         ob = cell_of(rb, ca);
      end
   end

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      sweep_in      = sweep_ff;
      mode_in       = mode_ff;
      lit_in        = lit_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      pa_in         = pa_ff;
      ob_in         = ob_ff;
      la_in         = la_ff;
      lb_in         = lb_ff;
      mem           = '0;
      emit          = '0;
      req_stall     = (state_ff != ST_IDLE);
      lit           = letter_index(req_data.in_byte);
      place_en      = 1'b0;
      place_idx     = sweep_ff;
      used_base     = used_ff;
      fill_base     = fill_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mode_in = req_data.mode;
               lit_in  = lit;
               unique case (req_data.mode)
                  MODE_KEY: begin
                     if (phase_ff != PHASE_KEY) begin
                        phase_in      = PHASE_KEY;
                        pend_valid_in = 1'b0;
                        used_base     = '0;
                        fill_base     = '0;
                     end
                     place_en  = lit.ok;
                     place_idx = lit.idx;
                  end
                  MODE_MSG, MODE_END: begin
                     sweep_in = '0;
                     state_in = (phase_ff == PHASE_KEY) ? ST_FILL : ST_PROC;
                  end
                  default: ;
               endcase
            end
         end
         ST_FILL: begin
            place_en = 1'b1;
            sweep_in = sweep_ff + 5'd1;
            if (sweep_ff == LAST_CELL) state_in = ST_PROC;
         end
         ST_PROC: begin
            state_in = ST_IDLE;
            if (mode_ff == MODE_MSG) begin
               phase_in = PHASE_MSG;
               if (lit_ff.ok) begin
                  if (!pend_valid_ff) begin
                     pend_in       = lit_ff.idx;
                     pend_valid_in = 1'b1;
                  end else begin
                     a_in     = pend_ff;
                     state_in = ST_RDA;
                     if (lit_ff.idx == pend_ff) begin
                        b_in = FILLER_INDEX;
                     end else begin
                        b_in          = lit_ff.idx;
                        pend_valid_in = 1'b0;
                     end
                  end
               end
            end else begin
               phase_in = PHASE_ENDED;
               if (pend_valid_ff) begin
                  pend_valid_in = 1'b0;
                  a_in          = pend_ff;
                  b_in          = FILLER_INDEX;
                  state_in      = ST_RDA;
               end
            end
         end
         ST_RDA: begin
            mem.pos_raddr = a_ff;
            state_in      = ST_RDB;
         end
         ST_RDB: begin
            mem.pos_raddr = b_ff;
            pa_in         = pos_rdata;
            state_in      = ST_CELL;
         end
         ST_CELL: begin
            mem.grid_raddr = oa;
            ob_in          = ob;
            state_in       = ST_GA;
         end
         ST_GA: begin
            mem.grid_raddr = ob_ff;
            la_in          = grid_rdata;
            state_in       = ST_GB;
         end
         ST_GB: begin
            lb_in    = grid_rdata;
            state_in = ST_EMIT0;
         end
         ST_EMIT0: begin
            emit.valid              = emit_ok;
            emit.word.cipher_letter = letter_ascii(la_ff);
            emit.word.last          = 1'b0;
            if (emit_ok) state_in = ST_EMIT1;
         end
         ST_EMIT1: begin
            emit.valid              = emit_ok;
            emit.word.cipher_letter = letter_ascii(lb_ff);
            emit.word.last          = 1'b1;
            if (emit_ok) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      used_in = used_base;
      fill_in = fill_base;
      if (place_en && !used_base[place_idx] && (fill_base < 5'(CELLS))) begin
         mem.we              = 1'b1;
         mem.slot            = fill_base;
         mem.letter          = place_idx;
         used_in[place_idx]  = 1'b1;
         fill_in             = fill_base + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= PHASE_KEY;
         used_ff       <= '0;
         fill_ff       <= '0;
         pend_valid_ff <= 1'b0;
         pend_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         used_ff       <= used_in;
         fill_ff       <= fill_in;
         pend_valid_ff <= pend_valid_in;
         pend_ff       <= pend_in;
      end
      sweep_ff <= sweep_in;
      mode_ff  <= mode_in;
      lit_ff   <= lit_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      pa_ff    <= pa_in;
      ob_ff    <= ob_in;
      la_ff    <= la_in;
      lb_ff    <= lb_in;
   end

endmodule

`default_nettype wire

/* design/playfair_cipher_encryptor.sv */
// Playfair encryptor top level: sequencer, grid and position RAMs, output
// register. Uses pfe_pkg, pfe_ram, pfe_ctrl.
//
// Usage:
//   req_* carries one byte word per accept: mode (key, message, end) and
//   in_byte. rsp_* carries cipher letters; last marks the second of a pair.
//   Both sides use valid/stall; a word moves when valid is high, stall low.
// Sequence:
//   A key byte is placed in the grid as it is accepted. The first message
//   or end word while the key phase is open starts a completion sweep over
//   the alphabet, one letter a cycle into the grid RAM. A message byte that
//   closes a pair goes through two position RAM reads and two grid RAM reads
//   (one read port each) in the states PROC, RDA, RDB, CELL, GA and GB, and
//   then emits its two letters in EMIT0 and EMIT1, each waiting for room in
//   the output register. Other message bytes pass through PROC only.
// Reset clears the grid bookkeeping, phase and pending letter; the output
// register empties. While rsp_stall is high and the output register is full,
// the word holds and a sequencer with a letter to emit waits, holding req_stall high.
`default_nettype none

module playfair_cipher_encryptor
   import pfe_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_word_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_word_type      rsp_data
);

   mem_req_type  mem;
   emit_type     emit;
   logic [4:0]   pos_rdata;
   logic [4:0]   grid_rdata;
   logic         emit_ok;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_data_ff, rsp_data_in;

   assign emit_ok = !rsp_valid_ff || !rsp_stall;

   pfe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .req_stall  (req_stall),
      .pos_rdata  (pos_rdata),
      .grid_rdata (grid_rdata),
      .emit_ok    (emit_ok),
      .mem        (mem),
      .emit       (emit)
   );

   pfe_ram #(.WIDTH(5), .DEPTH(CELLS)) u_grid_ram (
      .clock (clock),
      .we    (mem.we),
      .waddr (mem.slot),
      .wdata (mem.letter),
      .raddr (mem.grid_raddr),
      .rdata (grid_rdata)
   );

   pfe_ram #(.WIDTH(5), .DEPTH(CELLS)) u_pos_ram (
      .clock (clock),
      .we    (mem.we),
      .waddr (mem.letter),
      .wdata (mem.slot),
      .raddr (mem.pos_raddr),
      .rdata (pos_rdata)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit.valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit.word;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

/* design/pfe_checker.sv */
// Port-level assertions for the Playfair encryptor, bound to the top level.
// Uses pfe_pkg.
`default_nettype none

module pfe_checker
   import pfe_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_valid,
   input wire logic         req_stall,
   input wire req_word_type req_data,
   input wire logic         rsp_valid,
   input wire logic         rsp_stall,
   input wire rsp_word_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp word changed while stalled");

   a_letter_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.cipher_letter >= ASCII_A[6:0] &&
                    rsp_data.cipher_letter <= ASCII_Z[6:0] &&
                    rsp_data.cipher_letter != ASCII_J[6:0])
      else $error("cipher letter out of range");

   a_msg_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.mode == MODE_MSG || req_data.mode == MODE_END)
      |=> req_stall)
      else $error("message word did not occupy the sequencer");

   a_pair_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_data.last |=> !rsp_valid)
      else $error("letter follows end of pair too soon");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output not empty after reset");

endmodule

bind playfair_cipher_encryptor pfe_checker u_pfe_checker (.*);

`default_nettype wire

/* bench/cipher_checker.sv */
`timescale 1ns / 1ps
// Checker for the Playfair encryptor: watches both channels, predicts the
// cipher letters of every accepted word and compares them. Uses pfe_pkg.
module cipher_checker
   import pfe_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_stall,
   input  req_word_type req_data,
   input  wire logic    rsp_valid,
   input  wire logic    rsp_stall,
   input  rsp_word_type rsp_data,
   output int           mismatches,
   output int           backlog,
   output int           letters_seen
);

   typedef enum logic [1:0] {TAKING_KEY, TAKING_MSG, MSG_ENDED} stage_type;

   localparam int DUE_DEPTH = 64;

   logic [4:0]   grid [CELLS];
   logic [4:0]   cell_of_letter [CELLS];
   logic         placed [CELLS];
   int           filled;
   stage_type    stage;
   logic [4:0]   held;
   logic         held_ok;
   rsp_word_type cipher_due [DUE_DEPTH];
   int           due_wr;
   int           due_rd;
   rsp_word_type want;
   int           err_count;
   int           seen_count;

   // {is_letter, index}; J folds onto I
   function automatic logic [5:0] clean_letter(input logic [7:0] b);
      logic [7:0] u;
      u = (b >= ASCII_LOWER_A && b <= ASCII_LOWER_Z) ? b - CASE_OFFSET : b;
      if (u < ASCII_A || u > ASCII_Z) return 6'd0;
      u = u - ASCII_A;
      if (u >= J_OFFSET) u = u - 8'd1;
      return {1'b1, u[4:0]};
   endfunction

   function automatic logic [6:0] glyph(input logic [4:0] idx);
      return ASCII_A[6:0] + {2'b00, idx} + ((idx >= J_OFFSET[4:0]) ? 7'd1 : 7'd0);
   endfunction

   task automatic report(input string what, input logic [7:0] got, input logic [7:0] exp);
      err_count++;
      $display("%0t: %s: got %h, expected %h", $time, what, got, exp);
   endtask

   task automatic expect_letter(input rsp_word_type w);
      cipher_due[due_wr % DUE_DEPTH] = w;
      due_wr++;
   endtask

   task automatic wipe_grid();
      for (int i = 0; i < CELLS; i++) begin
         grid[i] = '0;
         cell_of_letter[i] = '0;
         placed[i] = 1'b0;
      end
      filled = 0;
   endtask

   task automatic place(input logic [4:0] idx);
      if (!placed[idx] && filled < CELLS) begin
         grid[filled] = idx;
         cell_of_letter[idx] = 5'(filled);
         placed[idx] = 1'b1;
         filled++;
      end
   endtask

   task automatic fill_rest();
      for (int i = 0; i < CELLS; i++) place(5'(i));
   endtask

   task automatic encrypt_pair(input logic [4:0] a, input logic [4:0] b);
      int pa, pb, ra, ca, rb, cb, oa, ob;
      rsp_word_type w;
      pa = cell_of_letter[a];
      pb = cell_of_letter[b];
      ra = pa / SIDE;
      ca = pa % SIDE;
      rb = pb / SIDE;
      cb = pb % SIDE;
      if (ra == rb) begin
         oa = ra * SIDE + (ca + 1) % SIDE;
         ob = rb * SIDE + (cb + 1) % SIDE;
      end else if (ca == cb) begin
         oa = ((ra + 1) % SIDE) * SIDE + ca;
         ob = ((rb + 1) % SIDE) * SIDE + cb;
      end else begin
         oa = ra * SIDE + cb;
         ob = rb * SIDE + ca;
      end
      w.cipher_letter = glyph(grid[oa]);
      w.last = 1'b0;
      expect_letter(w);
      w.cipher_letter = glyph(grid[ob]);
      w.last = 1'b1;
      expect_letter(w);
   endtask

   task automatic absorb_word(input req_word_type w);
      logic [5:0] c;
      c = clean_letter(w.in_byte);
      case (w.mode)
         MODE_KEY: begin
            if (stage != TAKING_KEY) begin
               wipe_grid();
               stage = TAKING_KEY;
               held = '0;
               held_ok = 1'b0;
            end
            if (c[5]) place(c[4:0]);
         end
         MODE_MSG: begin
            if (stage == TAKING_KEY) fill_rest();
            stage = TAKING_MSG;
            if (c[5]) begin
               if (!held_ok) begin
                  held = c[4:0];
                  held_ok = 1'b1;
               end else if (c[4:0] == held) begin
                  encrypt_pair(held, FILLER_INDEX);
               end else begin
                  held_ok = 1'b0;
                  encrypt_pair(held, c[4:0]);
               end
            end
         end
         MODE_END: begin
            if (stage == TAKING_KEY) fill_rest();
            stage = MSG_ENDED;
            if (held_ok) begin
               held_ok = 1'b0;
               encrypt_pair(held, FILLER_INDEX);
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         wipe_grid();
         stage = TAKING_KEY;
         held = '0;
         held_ok = 1'b0;
         due_wr = 0;
         due_rd = 0;
         err_count = 0;
         seen_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen_count++;
            if (due_wr == due_rd) begin
               report("unexpected word", 8'(rsp_data), 8'h00);
            end else begin
               want = cipher_due[due_rd % DUE_DEPTH];
               due_rd++;
               if (rsp_data.cipher_letter !== want.cipher_letter)
                  report("cipher_letter", 8'(rsp_data.cipher_letter),
                         8'(want.cipher_letter));
               if (rsp_data.last !== want.last)
                  report("last", 8'(rsp_data.last), 8'(want.last));
            end
         end
         if (req_valid && !req_stall) absorb_word(req_data);
      end
      mismatches <= err_count;
      backlog <= due_wr - due_rd;
      letters_seen <= seen_count;
   end

endmodule

/* bench/tb_playfair_cipher_encryptor.sv */
`timescale 1ns / 1ps
// Top of the Playfair encryptor bench: clock, reset, key and message words
// with random gaps and output stalls, and the verdict. Uses pfe_pkg,
// cipher_checker and playfair_cipher_encryptor.
module tb_playfair_cipher_encryptor;
   import pfe_pkg::*;

   localparam logic [1:0] MODE_NONE = 2'd3;
   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 80;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_data;

   int mismatches, backlog, letters_seen;
   int sent, useful, rounds, quiet;
   bit gaps_on, stall_on, hold_request;

   playfair_cipher_encryptor dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   cipher_checker checker_i (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .mismatches(mismatches),
      .backlog(backlog),
      .letters_seen(letters_seen)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("Timeout after %0d idle cycles", quiet);
         $display("Mismatches found");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   // receiver: random stall bursts, one long hold on request
   initial begin
      rsp_stall = 1'b0;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (stall_on && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   end

   task automatic send(input logic [1:0] m, input logic [7:0] b);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{mode: m, in_byte: b};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
      if (m != MODE_NONE) useful++;
   endtask

   function automatic logic [7:0] any_letter();
      logic [7:0] b;
      b = ASCII_A + 8'($urandom_range(0, 25));
      return $urandom_range(0, 1) ? b + CASE_OFFSET : b;
   endfunction

   task automatic session(input bit long_msg);
      int n, r;
      logic [7:0] prev;
      rounds++;
      prev = "X";
      if ($urandom_range(0, 7) != 0) begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 40) : $urandom_range(1, 12);
         repeat (n) begin
            r = $urandom_range(0, 19);
            if (r < 17) send(MODE_KEY, any_letter());
            else if (r < 19) send(MODE_KEY, 8'($urandom));
            else send(MODE_NONE, 8'($urandom));
         end
         if ($urandom_range(0, 9) == 0) send(MODE_END, 8'($urandom));
      end
      if (long_msg) n = 40;
      else n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 40) : $urandom_range(1, 14);
      repeat (n) begin
         r = $urandom_range(0, 19);
         if (r < 4) begin
            send(MODE_MSG, $urandom_range(0, 1) ? (prev ^ CASE_OFFSET) : prev);
         end else if (r == 4) begin
            prev = $urandom_range(0, 1) ? "x" : "X";
            send(MODE_MSG, prev);
         end else if (r == 5) begin
            send(MODE_MSG, 8'($urandom));
         end else if (r == 6) begin
            send(MODE_NONE, 8'($urandom));
         end else begin
            prev = any_letter();
            send(MODE_MSG, prev);
         end
      end
      if ($urandom_range(0, 4) != 0) send(MODE_END, 8'($urandom));
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      gaps_on = 1'b1;
      stall_on = 1'b1;
      hold_request = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // key with case, J, non-letters, extremes
      send(MODE_KEY, "k");
      send(MODE_KEY, "E");
      send(MODE_KEY, "y");
      send(MODE_KEY, "J");
      send(MODE_KEY, 8'h00);
      send(MODE_KEY, 8'hFF);
      send(MODE_KEY, "Z");
      send(MODE_KEY, "a");
      send(MODE_NONE, "Q");
      // doubled letters, doubled X, J in message, dropped byte, lone last letter
      send(MODE_MSG, "h");
      send(MODE_MSG, "i");
      send(MODE_MSG, "d");
      send(MODE_MSG, "d");
      send(MODE_MSG, "x");
      send(MODE_MSG, "x");
      send(MODE_MSG, "!");
      send(MODE_MSG, "j");
      send(MODE_MSG, "Z");
      send(MODE_END, 8'hFF);
      send(MODE_END, 8'h00);
      // new message on the same grid
      send(MODE_MSG, "a");
      send(MODE_END, 8'h00);
      // new key, end while still taking key
      send(MODE_KEY, "m");
      send(MODE_END, 8'h00);
      send(MODE_MSG, "b");
      send(MODE_MSG, "c");

      while (useful < 420) session(1'b0);
      hold_request = 1'b1;
      session(1'b1);
      while (useful < 600) session(1'b0);
      gaps_on = 1'b0;
      stall_on = 1'b0;
      while (useful < 750) session(1'b0);
      req_valid <= 1'b0;

      while (backlog != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Sent %0d words (%0d key, message or flush) in %0d rounds", sent, useful, rounds);
      $display("Checked %0d cipher letters, %0d mismatching", letters_seen, mismatches);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
